FILE: rtl/packet_class_statistics_macros.svh
// assertion helpers
`ifndef PACKET_CLASS_STATISTICS_MACROS_SVH
`define PACKET_CLASS_STATISTICS_MACROS_SVH
`define PCS_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define PCS_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

FILE: rtl/pcs_pkg.sv
package pcs_pkg;
	localparam int PortEntriesDefault = 1024;
	localparam logic [15:0] EthIpv4 = 16'h0800;
	localparam logic [15:0] EthArp = 16'h0806;
	localparam logic [16:0] SizeReset = 17'd1518;
	localparam logic [3:0] CcIpv4 = 4'd0, CcArpReq = 4'd1, CcArpRep = 4'd2, CcIcmpRep = 4'd3,
		CcIcmpReq = 4'd4, CcUdp = 4'd5, CcTcp = 4'd6, CcHttp = 4'd7, CcDns = 4'd8,
		CcHttps = 4'd9, CcTelnet = 4'd10;
	localparam int CcSlots = 11;
	localparam logic [1:0] RegHttp = 2'd0, RegDns = 2'd1, RegHttps = 2'd2, RegTelnet = 2'd3;

	// frame class codes
	localparam logic [3:0] FcOther = 4'd0, FcArpReq = 4'd1, FcArpRep = 4'd2, FcArpOther = 4'd3,
		FcIcmpRep = 4'd4, FcIcmpReq = 4'd5, FcIcmpOther = 4'd6, FcUdp = 4'd7, FcTcp = 4'd8,
		FcIpv4Other = 4'd9;
	// application class codes
	localparam logic [2:0] AppNone = 3'd0, AppHttp = 3'd1, AppDns = 3'd2, AppHttps = 3'd3,
		AppTelnet = 3'd4;
	// header codes
	localparam logic [7:0] ProtoIcmp = 8'd1, ProtoTcp = 8'd6, ProtoUdp = 8'd17;
	localparam logic [7:0] IcmpEchoReply = 8'd0, IcmpEchoRequest = 8'd8;
	localparam logic [15:0] ArpRequest = 16'd1, ArpReply = 16'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SRC_START, ST_SEARCH, ST_WAIT, ST_CHECK, ST_UPDATE, ST_FINISH, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [15:0] key;
	} srch_req_t;

	typedef struct packed {
		logic done;
		logic found;
	} srch_rsp_t;
endpackage

FILE: rtl/packet_class_statistics.sv
// packet_class_statistics: classifies one frame header word and keeps class, size and
// port statistics. a frame other than udp or tcp passes accept, finish and result word
// in that order; udp and tcp add two linear searches of the port table at one entry per
// cycle, source port first, then destination port, between accept and finish. ready is
// low while a frame is in work; the result word is held until taken.
`include "packet_class_statistics_macros.svh"
module packet_class_statistics import pcs_pkg::*; #(
	parameter int PORT_ENTRIES = PortEntriesDefault,
	localparam int AW = $clog2(PORT_ENTRIES),
	localparam int CW = $clog2(PORT_ENTRIES + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [15:0] eth_type,
	input logic [7:0] ip_protocol,
	input logic [15:0] ip_total_length,
	input logic [7:0] icmp_type,
	input logic [15:0] arp_opcode,
	input logic [15:0] src_port,
	input logic [15:0] dst_port,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output logic [3:0] frame_class,
	output logic [2:0] app_class,
	output logic [31:0] class_count,
	output logic [31:0] app_count,
	output logic [31:0] packets_counted,
	output logic [47:0] total_bytes,
	output logic [16:0] min_size_seen,
	output logic [16:0] max_size_seen,
	output logic [31:0] src_port_hits,
	output logic [31:0] dst_port_hits,
	output logic [CW-1:0] ports_in_use,
	output logic table_full
);
	// configuration registers
	logic [15:0] http_q, dns_q, https_q, telnet_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			http_q <= 16'd80;
			dns_q <= 16'd53;
			https_q <= 16'd443;
			telnet_q <= 16'd23;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegHttp: http_q <= cfg_data;
				RegDns: dns_q <= cfg_data;
				RegHttps: https_q <= cfg_data;
				RegTelnet: telnet_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// statistics state
	logic [31:0] cc_q [CcSlots];
	logic [31:0] frames_q;
	logic [47:0] bytes_q;
	logic [16:0] least_q, greatest_q;
	logic [CW-1:0] used_q;

	// captured frame word
	logic [15:0] sp_q, dp_q;
	logic tcp_q, ports_q;
	logic second_q;
	logic [16:0] size_q;

	state_t state_q, state_d;
	srch_req_t req;
	srch_rsp_t rsp;
	logic found_q;
	logic [AW-1:0] hit_addr;
	logic [31:0] hit_count;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0] wr_count;
	logic [15:0] cur_key;
	logic [31:0] new_count;

	assign cur_key = second_q ? dp_q : sp_q;
	assign new_count = (hit_count == '1) ? hit_count : hit_count + 32'd1;

	pcs_port_table #(.PORT_ENTRIES(PORT_ENTRIES)) u_table (
		.clk, .arst_n, .req, .used(used_q), .wr_en, .wr_addr, .wr_key(cur_key),
		.wr_count, .rsp, .hit_addr, .hit_count
	);

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	// decode done at accept time; narrow compares only
	logic [3:0] fc_d;
	logic [16:0] sz_d;
	always_comb begin
		fc_d = FcOther;
		sz_d = 17'd14;
		if (eth_type == EthIpv4) begin
			sz_d = 17'd14 + {1'b0, ip_total_length};
			if (ip_protocol == ProtoIcmp)
				fc_d = (icmp_type == IcmpEchoReply) ? FcIcmpRep :
					(icmp_type == IcmpEchoRequest) ? FcIcmpReq : FcIcmpOther;
			else if (ip_protocol == ProtoUdp) fc_d = FcUdp;
			else if (ip_protocol == ProtoTcp) fc_d = FcTcp;
			else fc_d = FcIpv4Other;
		end else if (eth_type == EthArp) begin
			sz_d = 17'd42;
			fc_d = (arp_opcode == ArpRequest) ? FcArpReq :
				(arp_opcode == ArpReply) ? FcArpRep : FcArpOther;
		end
	end

	always_comb begin
		state_d = state_q;
		req = '{start: 1'b0, key: cur_key};
		wr_en = 1'b0;
		wr_addr = hit_addr;
		wr_count = new_count;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ((fc_d == FcUdp) || (fc_d == FcTcp)) ?
				ST_SRC_START : ST_FINISH;
			ST_SRC_START: begin
				req.start = 1'b1;
				state_d = ST_SEARCH;
			end
			ST_SEARCH: if (rsp.done) state_d = ST_WAIT;
			ST_WAIT: state_d = ST_CHECK;
			ST_CHECK: state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (found_q) begin
					wr_en = 1'b1;
				end else if (used_q < CW'(PORT_ENTRIES)) begin
					wr_en = 1'b1;
					wr_addr = used_q[AW-1:0];
					wr_count = 32'd1;
				end
				state_d = second_q ? ST_FINISH : ST_SRC_START;
			end
			ST_FINISH: state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	logic [3:0] slot;
	always_comb begin
		unique case (frame_class)
			FcArpReq: slot = CcArpReq;
			FcArpRep: slot = CcArpRep;
			FcIcmpRep: slot = CcIcmpRep;
			FcIcmpReq: slot = CcIcmpReq;
			FcUdp: slot = CcUdp;
			FcTcp: slot = CcTcp;
			default: slot = CcIpv4;
		endcase
	end

	logic http_m, dns_m, https_m, tel_m;
	assign http_m = tcp_q && (sp_q == http_q || dp_q == http_q);
	assign dns_m = sp_q == dns_q || dp_q == dns_q;
	assign https_m = tcp_q && (sp_q == https_q || dp_q == https_q);
	assign tel_m = tcp_q && (sp_q == telnet_q || dp_q == telnet_q);

	logic [47:0] bytes_sum;
	assign bytes_sum = bytes_q + {31'd0, size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < CcSlots; i++) cc_q[i] <= '0;
			frames_q <= '0;
			bytes_q <= '0;
			least_q <= SizeReset;
			greatest_q <= '0;
			used_q <= '0;
			second_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					frame_class <= fc_d;
					size_q <= sz_d;
					sp_q <= src_port;
					dp_q <= dst_port;
					tcp_q <= (fc_d == FcTcp);
					ports_q <= (fc_d == FcUdp) || (fc_d == FcTcp);
					second_q <= 1'b0;
					table_full <= 1'b0;
					src_port_hits <= '0;
					dst_port_hits <= '0;
					app_class <= AppNone;
					app_count <= '0;
					class_count <= '0;
				end
				ST_SEARCH: if (rsp.done) found_q <= rsp.found;
				ST_UPDATE: begin
					logic [31:0] h;
					h = 32'd0;
					if (found_q) h = new_count;
					else if (used_q < CW'(PORT_ENTRIES)) begin
						h = 32'd1;
						used_q <= used_q + 1'b1;
					end else table_full <= 1'b1;
					if (second_q) dst_port_hits <= h;
					else src_port_hits <= h;
					second_q <= 1'b1;
				end
				ST_FINISH: begin
					// every ipv4 class advances the ipv4 counter
					if (frame_class >= FcIcmpRep) cc_q[CcIpv4] <= sat_inc(cc_q[CcIpv4]);
					if (frame_class == FcIcmpOther || frame_class == FcIpv4Other)
						class_count <= sat_inc(cc_q[CcIpv4]);
					else if (frame_class != FcOther && frame_class != FcArpOther) begin
						cc_q[slot] <= sat_inc(cc_q[slot]);
						class_count <= sat_inc(cc_q[slot]);
					end
					if (ports_q) begin
						if (http_m) begin
							app_class <= AppHttp; cc_q[CcHttp] <= sat_inc(cc_q[CcHttp]);
							app_count <= sat_inc(cc_q[CcHttp]);
						end else if (dns_m) begin
							app_class <= AppDns; cc_q[CcDns] <= sat_inc(cc_q[CcDns]);
							app_count <= sat_inc(cc_q[CcDns]);
						end else if (https_m) begin
							app_class <= AppHttps; cc_q[CcHttps] <= sat_inc(cc_q[CcHttps]);
							app_count <= sat_inc(cc_q[CcHttps]);
						end else if (tel_m) begin
							app_class <= AppTelnet;
							cc_q[CcTelnet] <= sat_inc(cc_q[CcTelnet]);
							app_count <= sat_inc(cc_q[CcTelnet]);
						end
					end
					// counted only if larger than a bare header
					if (size_q > 17'd14) begin
						frames_q <= sat_inc(frames_q);
						bytes_q <= (bytes_sum < bytes_q) ? '1 : bytes_sum;
						if (size_q < least_q) least_q <= size_q;
						if (size_q > greatest_q) greatest_q <= size_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign packets_counted = frames_q;
	assign total_bytes = bytes_q;
	assign min_size_seen = least_q;
	assign max_size_seen = greatest_q;
	assign ports_in_use = used_q;

	`PCS_ASSERT_IMP(a_used_bound, clk, arst_n, 1'b1, used_q <= CW'(PORT_ENTRIES),
		"port table count out of range")
	`PCS_ASSERT_IMP(a_ready_excl, clk, arst_n, out_valid, !in_ready,
		"input taken while result pending")
	`PCS_ASSERT_NXT(a_full_used, clk, arst_n, state_q == ST_OUT && table_full,
		used_q == CW'(PORT_ENTRIES), "drop reported with free entries")
endmodule

FILE: rtl/pcs_port_table.sv
// port table memory with linear key search over valid entries
module pcs_port_table import pcs_pkg::*; #(
	parameter int PORT_ENTRIES = PortEntriesDefault,
	localparam int AW = $clog2(PORT_ENTRIES),
	localparam int CW = $clog2(PORT_ENTRIES + 1)
) (
	input logic clk,
	input logic arst_n,
	input srch_req_t req,
	input logic [CW-1:0] used,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [15:0] wr_key,
	input logic [31:0] wr_count,
	output srch_rsp_t rsp,
	output logic [AW-1:0] hit_addr,
	output logic [31:0] hit_count
);
	logic [15:0] keys [PORT_ENTRIES];
	logic [31:0] counts [PORT_ENTRIES];
	logic [15:0] key_q;
	logic [CW-1:0] idx_q;
	logic busy_q, rd_vld_q;
	logic [15:0] rd_key_q;
	logic [AW-1:0] rd_addr_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			keys[wr_addr] <= wr_key;
			counts[wr_addr] <= wr_count;
		end
		rd_key_q <= keys[idx_q[AW-1:0]];
		hit_count <= counts[rd_addr_q];
	end

	// one read per cycle, compared in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rd_vld_q <= 1'b0;
			idx_q <= '0;
			rsp <= '0;
		end else begin
			rsp <= '0;
			if (req.start) begin
				busy_q <= 1'b1;
				rd_vld_q <= 1'b0;
				idx_q <= '0;
				key_q <= req.key;
			end else if (busy_q) begin
				if (rd_vld_q && rd_key_q == key_q) begin
					busy_q <= 1'b0;
					rd_vld_q <= 1'b0;
					rsp <= '{done: 1'b1, found: 1'b1};
				end else if (idx_q >= used) begin
					busy_q <= 1'b0;
					rd_vld_q <= 1'b0;
					rsp <= '{done: 1'b1, found: 1'b0};
				end else begin
					rd_addr_q <= idx_q[AW-1:0];
					rd_vld_q <= 1'b1;
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end
	assign hit_addr = rd_addr_q;
endmodule

FILE: test/tb.sv
module tb;
	import pcs_pkg::*;

	localparam int TableDepth = 1024;
	localparam int CycleLimit = 10000000;
	localparam int RandomItems = 280;

	// one frame header word as the sender drives it
	typedef struct {
		logic [15:0] eth_type;
		logic [7:0] ip_protocol;
		logic [15:0] ip_total_length;
		logic [7:0] icmp_type;
		logic [15:0] arp_opcode;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} frame_hdr_t;

	// one statistics word as the block returns it
	typedef struct {
		logic [3:0] frame_class;
		logic [2:0] app_class;
		logic [31:0] class_count;
		logic [31:0] app_count;
		logic [31:0] packets_counted;
		logic [47:0] total_bytes;
		logic [16:0] min_size_seen;
		logic [16:0] max_size_seen;
		logic [31:0] src_port_hits;
		logic [31:0] dst_port_hits;
		logic [10:0] ports_in_use;
		logic table_full;
	} frame_stats_t;

	// directed row: header plus, where obvious, the class codes typed in
	typedef struct {
		frame_hdr_t hdr;
		bit typed;
		logic [3:0] frame_class;
		logic [2:0] app_class;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [15:0] eth_type;
	logic [7:0] ip_protocol;
	logic [15:0] ip_total_length;
	logic [7:0] icmp_type;
	logic [15:0] arp_opcode;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic out_valid;
	logic out_ready;
	logic [3:0] frame_class;
	logic [2:0] app_class;
	logic [31:0] class_count;
	logic [31:0] app_count;
	logic [31:0] packets_counted;
	logic [47:0] total_bytes;
	logic [16:0] min_size_seen;
	logic [16:0] max_size_seen;
	logic [31:0] src_port_hits;
	logic [31:0] dst_port_hits;
	logic [10:0] ports_in_use;
	logic table_full;

	packet_class_statistics i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.eth_type(eth_type),
		.ip_protocol(ip_protocol),
		.ip_total_length(ip_total_length),
		.icmp_type(icmp_type),
		.arp_opcode(arp_opcode),
		.src_port(src_port),
		.dst_port(dst_port),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_class(frame_class),
		.app_class(app_class),
		.class_count(class_count),
		.app_count(app_count),
		.packets_counted(packets_counted),
		.total_bytes(total_bytes),
		.min_size_seen(min_size_seen),
		.max_size_seen(max_size_seen),
		.src_port_hits(src_port_hits),
		.dst_port_hits(dst_port_hits),
		.ports_in_use(ports_in_use),
		.table_full(table_full)
	);

	// shadow of the block state, kept by the predictor
	logic [15:0] http_sh, dns_sh, https_sh, telnet_sh;
	logic [31:0] class_ctr [CcSlots];
	logic [31:0] frames_sh;
	logic [47:0] bytes_sh;
	logic [16:0] least_sh, greatest_sh;
	logic [15:0] port_key_sh [TableDepth];
	logic [31:0] port_cnt_sh [TableDepth];
	int ports_used_sh;

	frame_stats_t expected_stats [$];
	int errors;
	int cycles;
	int send_idle_pct;
	int recv_idle_pct;
	int recv_hold;

	// clock and cycle limit
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// saturating bump of one class counter, returns the new value
	function automatic logic [31:0] bump_class(input logic [3:0] slot);
		if (class_ctr[slot] != 32'hFFFF_FFFF)
			class_ctr[slot] = class_ctr[slot] + 1;
		return class_ctr[slot];
	endfunction

	// count one port in the shadow table; 0 and dropped set when full
	function automatic logic [31:0] count_port(input logic [15:0] key, inout logic dropped);
		for (int i = 0; i < ports_used_sh; i++) begin
			if (port_key_sh[i] == key) begin
				if (port_cnt_sh[i] != 32'hFFFF_FFFF)
					port_cnt_sh[i] = port_cnt_sh[i] + 1;
				return port_cnt_sh[i];
			end
		end
		if (ports_used_sh < TableDepth) begin
			port_key_sh[ports_used_sh] = key;
			port_cnt_sh[ports_used_sh] = 1;
			ports_used_sh++;
			return 1;
		end
		dropped = 1'b1;
		return 0;
	endfunction

	function automatic bit port_match(input frame_hdr_t h, input logic [15:0] p);
		return h.src_port == p || h.dst_port == p;
	endfunction

	// classify one header and advance the shadow statistics
	function automatic frame_stats_t frame_statistics(input frame_hdr_t h);
		frame_stats_t r;
		logic [31:0] v4;
		logic [16:0] size;
		logic dropped;
		bit tcp;
		r = '{default: '0};
		dropped = 1'b0;
		size = 17'd14;
		if (h.eth_type == EthIpv4) begin
			v4 = bump_class(CcIpv4);
			size = 17'd14 + h.ip_total_length;
			if (h.ip_protocol == ProtoIcmp) begin
				if (h.icmp_type == IcmpEchoReply) begin
					r.frame_class = FcIcmpRep;
					r.class_count = bump_class(CcIcmpRep);
				end else if (h.icmp_type == IcmpEchoRequest) begin
					r.frame_class = FcIcmpReq;
					r.class_count = bump_class(CcIcmpReq);
				end else begin
					r.frame_class = FcIcmpOther;
					r.class_count = v4;
				end
			end else if (h.ip_protocol == ProtoUdp || h.ip_protocol == ProtoTcp) begin
				tcp = (h.ip_protocol == ProtoTcp);
				r.frame_class = tcp ? FcTcp : FcUdp;
				r.class_count = bump_class(tcp ? CcTcp : CcUdp);
				r.src_port_hits = count_port(h.src_port, dropped);
				r.dst_port_hits = count_port(h.dst_port, dropped);
				// priority: http, dns, https, telnet
				if (tcp && port_match(h, http_sh)) begin
					r.app_class = AppHttp;
					r.app_count = bump_class(CcHttp);
				end else if (port_match(h, dns_sh)) begin
					r.app_class = AppDns;
					r.app_count = bump_class(CcDns);
				end else if (tcp && port_match(h, https_sh)) begin
					r.app_class = AppHttps;
					r.app_count = bump_class(CcHttps);
				end else if (tcp && port_match(h, telnet_sh)) begin
					r.app_class = AppTelnet;
					r.app_count = bump_class(CcTelnet);
				end
			end else begin
				r.frame_class = FcIpv4Other;
				r.class_count = v4;
			end
		end else if (h.eth_type == EthArp) begin
			size = 17'd42;
			if (h.arp_opcode == ArpRequest) begin
				r.frame_class = FcArpReq;
				r.class_count = bump_class(CcArpReq);
			end else if (h.arp_opcode == ArpReply) begin
				r.frame_class = FcArpRep;
				r.class_count = bump_class(CcArpRep);
			end else begin
				r.frame_class = FcArpOther;
			end
		end
		// only frames longer than the bare header are counted
		if (size > 17'd14) begin
			if (frames_sh != 32'hFFFF_FFFF)
				frames_sh = frames_sh + 1;
			if (bytes_sh > 48'hFFFF_FFFF_FFFF - size)
				bytes_sh = 48'hFFFF_FFFF_FFFF;
			else
				bytes_sh = bytes_sh + size;
			if (size < least_sh)
				least_sh = size;
			if (size > greatest_sh)
				greatest_sh = size;
		end
		r.packets_counted = frames_sh;
		r.total_bytes = bytes_sh;
		r.min_size_seen = least_sh;
		r.max_size_seen = greatest_sh;
		r.ports_in_use = ports_used_sh[10:0];
		r.table_full = dropped;
		return r;
	endfunction

	// predict on every accepted header word
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			frame_hdr_t h;
			h.eth_type = eth_type;
			h.ip_protocol = ip_protocol;
			h.ip_total_length = ip_total_length;
			h.icmp_type = icmp_type;
			h.arp_opcode = arp_opcode;
			h.src_port = src_port;
			h.dst_port = dst_port;
			expected_stats.push_back(frame_statistics(h));
		end
	end

	// receiver ready: random idling, or a counted long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_hold > 0) begin
				out_ready = 1'b0;
				recv_hold = recv_hold - 1;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic report(input string name, input logic [63:0] exp_v, input logic [63:0] got_v);
		$display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, got_v);
		errors++;
	endtask

	// compare each taken result word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			frame_stats_t e;
			if (expected_stats.size() == 0) begin
				$display("%0t: result word with nothing expected", $time);
				errors++;
			end else begin
				e = expected_stats.pop_front();
				if (frame_class !== e.frame_class)
					report("frame_class", e.frame_class, frame_class);
				if (app_class !== e.app_class)
					report("app_class", e.app_class, app_class);
				if (class_count !== e.class_count)
					report("class_count", e.class_count, class_count);
				if (app_count !== e.app_count)
					report("app_count", e.app_count, app_count);
				if (packets_counted !== e.packets_counted)
					report("packets_counted", e.packets_counted, packets_counted);
				if (total_bytes !== e.total_bytes)
					report("total_bytes", e.total_bytes, total_bytes);
				if (min_size_seen !== e.min_size_seen)
					report("min_size_seen", e.min_size_seen, min_size_seen);
				if (max_size_seen !== e.max_size_seen)
					report("max_size_seen", e.max_size_seen, max_size_seen);
				if (src_port_hits !== e.src_port_hits)
					report("src_port_hits", e.src_port_hits, src_port_hits);
				if (dst_port_hits !== e.dst_port_hits)
					report("dst_port_hits", e.dst_port_hits, dst_port_hits);
				if (ports_in_use !== e.ports_in_use)
					report("ports_in_use", e.ports_in_use, ports_in_use);
				if (table_full !== e.table_full)
					report("table_full", e.table_full, table_full);
			end
		end
	end

	// drive one header word, with a random gap first, and wait until taken
	task automatic send_frame(input frame_hdr_t h);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		eth_type = h.eth_type;
		ip_protocol = h.ip_protocol;
		ip_total_length = h.ip_total_length;
		icmp_type = h.icmp_type;
		arp_opcode = h.arp_opcode;
		src_port = h.src_port;
		dst_port = h.dst_port;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
	endtask

	// lower valid and wait until every expected word has come back
	task automatic drain;
		in_valid = 1'b0;
		while (expected_stats.size() != 0)
			@(negedge clk);
	endtask

	// register write, only issued while the block is idle
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			RegHttp: http_sh = val;
			RegDns: dns_sh = val;
			RegHttps: https_sh = val;
			default: telnet_sh = val;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_ports(input logic [15:0] http_v, input logic [15:0] dns_v,
			input logic [15:0] https_v, input logic [15:0] telnet_v);
		write_reg(RegHttp, http_v);
		write_reg(RegDns, dns_v);
		write_reg(RegHttps, https_v);
		write_reg(RegTelnet, telnet_v);
	endtask

	// port pick: configured ports, a small pool, or any value
	function automatic logic [15:0] pick_port;
		case ($urandom_range(7))
			0: return http_sh;
			1: return dns_sh;
			2: return https_sh;
			3: return telnet_sh;
			4: return 16'($urandom_range(65535));
			default: return 16'd1000 + 16'($urandom_range(31));
		endcase
	endfunction

	// mostly well-formed ipv4 and arp headers, some noise
	function automatic frame_hdr_t random_frame;
		frame_hdr_t h;
		int sel;
		h.eth_type = 16'($urandom_range(65535));
		h.ip_protocol = 8'($urandom_range(255));
		h.ip_total_length = 16'($urandom_range(65535));
		h.icmp_type = 8'($urandom_range(255));
		h.arp_opcode = 16'($urandom_range(65535));
		h.src_port = pick_port();
		h.dst_port = pick_port();
		sel = $urandom_range(99);
		if (sel < 70) begin
			h.eth_type = EthIpv4;
			case ($urandom_range(9))
				0, 1: h.ip_protocol = ProtoIcmp;
				2, 3, 4: h.ip_protocol = ProtoUdp;
				5, 6, 7, 8: h.ip_protocol = ProtoTcp;
				default: ;
			endcase
			if ($urandom_range(3) != 0)
				h.icmp_type = $urandom_range(1) ? IcmpEchoRequest : IcmpEchoReply;
			if ($urandom_range(7) != 0)
				h.ip_total_length = 16'($urandom_range(1500, 20));
		end else if (sel < 88) begin
			h.eth_type = EthArp;
			if ($urandom_range(3) != 0)
				h.arp_opcode = $urandom_range(1) ? ArpReply : ArpRequest;
		end
		return h;
	endfunction

	function automatic frame_hdr_t hdr(input logic [15:0] et, input logic [7:0] pr,
			input logic [15:0] len, input logic [7:0] it, input logic [15:0] op,
			input logic [15:0] sp, input logic [15:0] dp);
		frame_hdr_t h;
		h = '{et, pr, len, it, op, sp, dp};
		return h;
	endfunction

	directed_row_t directed [] = '{
		'{hdr(EthArp, 8'd0, 16'd0, 8'd0, ArpRequest, 16'd0, 16'd0), 1'b1, FcArpReq, AppNone},
		'{hdr(EthArp, 8'hFF, 16'hFFFF, 8'hFF, ArpReply, 16'hFFFF, 16'hFFFF), 1'b1,
			FcArpRep, AppNone},
		'{hdr(EthArp, ProtoIcmp, 16'd60, 8'd0, 16'hFFFF, 16'd80, 16'd80), 1'b1,
			FcArpOther, AppNone},
		'{hdr(16'hFFFF, ProtoTcp, 16'd60, 8'd0, ArpRequest, 16'd80, 16'd80), 1'b1,
			FcOther, AppNone},
		'{hdr(16'h0000, ProtoUdp, 16'd60, IcmpEchoRequest, ArpReply, 16'd53, 16'd53), 1'b1,
			FcOther, AppNone},
		'{hdr(EthIpv4, ProtoIcmp, 16'd84, IcmpEchoReply, 16'd0, 16'd0, 16'd0), 1'b1,
			FcIcmpRep, AppNone},
		'{hdr(EthIpv4, ProtoIcmp, 16'd84, IcmpEchoRequest, 16'd0, 16'd0, 16'd0), 1'b1,
			FcIcmpReq, AppNone},
		'{hdr(EthIpv4, ProtoIcmp, 16'd84, 8'hFF, 16'd0, 16'd0, 16'd0), 1'b1,
			FcIcmpOther, AppNone},
		// zero length: ipv4 counters move, frame not counted
		'{hdr(EthIpv4, 8'hFF, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0), 1'b1, FcIpv4Other, AppNone},
		'{hdr(EthIpv4, 8'd0, 16'hFFFF, 8'd0, 16'd0, 16'd0, 16'd0), 1'b1, FcIpv4Other, AppNone},
		'{hdr(EthIpv4, ProtoUdp, 16'd60, 8'd0, 16'd0, 16'd53, 16'd1000), 1'b1, FcUdp, AppDns},
		// same port on both sides: entry counted twice
		'{hdr(EthIpv4, ProtoUdp, 16'd60, 8'd0, 16'd0, 16'd80, 16'd80), 1'b1, FcUdp, AppNone},
		'{hdr(EthIpv4, ProtoTcp, 16'd60, 8'd0, 16'd0, 16'd80, 16'd53), 1'b1, FcTcp, AppHttp},
		'{hdr(EthIpv4, ProtoTcp, 16'd60, 8'd0, 16'd0, 16'd1, 16'd53), 1'b1, FcTcp, AppDns},
		'{hdr(EthIpv4, ProtoTcp, 16'd60, 8'd0, 16'd0, 16'd443, 16'd1), 1'b1, FcTcp, AppHttps},
		'{hdr(EthIpv4, ProtoTcp, 16'd60, 8'd0, 16'd0, 16'd2, 16'd23), 1'b1, FcTcp, AppTelnet},
		'{hdr(EthIpv4, ProtoTcp, 16'd60, 8'd0, 16'd0, 16'd0, 16'hFFFF), 1'b1, FcTcp, AppNone},
		'{hdr(EthIpv4, ProtoTcp, 16'd40, 8'd0, 16'd0, 16'd443, 16'd23), 1'b1, FcTcp, AppHttps},
		'{hdr(EthIpv4, ProtoUdp, 16'd40, 8'd0, 16'd0, 16'd443, 16'd23), 1'b1, FcUdp, AppNone},
		// larger than the reset minimum
		'{hdr(EthIpv4, ProtoUdp, 16'd2000, 8'd0, 16'd0, 16'h8000, 16'h7FFF), 1'b0,
			FcOther, AppNone},
		'{hdr(EthIpv4, ProtoIcmp, 16'd1, 8'd0, 16'd0, 16'd0, 16'd0), 1'b0, FcOther, AppNone},
		'{hdr(EthIpv4, ProtoTcp, 16'd1500, 8'h55, 16'hAAAA, 16'h5555, 16'hAAAA), 1'b0,
			FcOther, AppNone}
	};

	// stimulus
	initial begin
		int fill_key;
		frame_stats_t e;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cfg_valid = 1'b0;
		out_ready = 1'b0;
		cfg_index = RegHttp;
		cfg_data = '0;
		eth_type = '0;
		ip_protocol = '0;
		ip_total_length = '0;
		icmp_type = '0;
		arp_opcode = '0;
		src_port = '0;
		dst_port = '0;
		errors = 0;
		cycles = 0;
		recv_hold = 0;
		send_idle_pct = 18;
		recv_idle_pct = 71;
		http_sh = 16'd80;
		dns_sh = 16'd53;
		https_sh = 16'd443;
		telnet_sh = 16'd23;
		for (int i = 0; i < CcSlots; i++)
			class_ctr[i] = '0;
		frames_sh = '0;
		bytes_sh = '0;
		least_sh = SizeReset;
		greatest_sh = '0;
		ports_used_sh = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed rows with reset register values
		for (int i = 0; i < directed.size(); i++) begin
			send_frame(directed[i].hdr);
			// typed class codes override the predictor for those fields
			if (directed[i].typed) begin
				e = expected_stats[expected_stats.size() - 1];
				e.frame_class = directed[i].frame_class;
				e.app_class = directed[i].app_class;
				expected_stats[expected_stats.size() - 1] = e;
			end
		end
		drain();

		// random phase one: sender idles little, receiver a lot
		write_ports(16'd8080, 16'd5353, 16'd8443, 16'd2323);
		for (int i = 0; i < RandomItems / 3; i++) begin
			send_frame(random_frame());
			// one pause until everything is back
			if (i == RandomItems / 6)
				drain();
		end
		drain();

		// phase two: extreme port values, roles swapped
		send_idle_pct = 71;
		recv_idle_pct = 18;
		write_ports(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
		for (int i = 0; i < RandomItems / 3; i++)
			send_frame(random_frame());
		drain();

		// phase three: no idling, long receiver hold-off at the start
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_ports(16'd80, 16'd53, 16'd443, 16'd23);
		recv_hold = 400;
		for (int i = 0; i < RandomItems - 2 * (RandomItems / 3); i++)
			send_frame(random_frame());
		drain();

		// fill the port table with fresh keys, then hit it while full
		fill_key = 16'hF000;
		while (ports_used_sh < TableDepth) begin
			send_frame(hdr(EthIpv4, ProtoUdp, 16'd100, 8'd0, 16'd0, fill_key[15:0],
				fill_key[15:0] + 16'd1));
			fill_key += 2;
			if (ports_used_sh >= TableDepth - 2)
				drain();
		end
		drain();
		for (int i = 0; i < 8; i++) begin
			frame_hdr_t h;
			h = random_frame();
			h.eth_type = EthIpv4;
			h.ip_protocol = $urandom_range(1) ? ProtoTcp : ProtoUdp;
			if (i[0])
				h.src_port = 16'hF000 + 16'($urandom_range(63));
			send_frame(h);
		end
		drain();

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
